### design/its_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

   // parameter defaults
   localparam int MODE_STACK_DEPTH_DEF  = 16;
   localparam int MAX_COMMENT_DEPTH_DEF = 255;
   localparam int OFFSET_BITS_DEF       = 24;

   // result queue
   localparam int RSP_DEPTH   = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [19:0] LINE_MAX = 20'hFFFFF;
   localparam logic [15:0] COL_MAX  = 16'hFFFF;
   localparam logic [15:0] LEN_MAX  = 16'hFFFF;

   // lookahead markers beside a real byte
   localparam logic [8:0] PEEK_END  = 9'h100;
   localparam logic [8:0] PEEK_NONE = 9'h101;

   localparam logic MODE_DEF = 1'b0;
   localparam logic MODE_STR = 1'b1;

   // characters
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LE     = 8'h65;
   localparam logic [7:0] CH_UE     = 8'h45;

   // token kinds
   localparam logic [5:0] TK_ERR          = 6'd0;
   localparam logic [5:0] TK_EOF          = 6'd1;
   localparam logic [5:0] TK_NUM          = 6'd2;
   localparam logic [5:0] TK_IDENT        = 6'd3;
   localparam logic [5:0] TK_SYS          = 6'd4;
   localparam logic [5:0] TK_PLUS         = 6'd5;
   localparam logic [5:0] TK_PLUS_EQ      = 6'd6;
   localparam logic [5:0] TK_PLUS_PLUS    = 6'd7;
   localparam logic [5:0] TK_MINUS        = 6'd8;
   localparam logic [5:0] TK_MINUS_EQ     = 6'd9;
   localparam logic [5:0] TK_MINUS_MINUS  = 6'd10;
   localparam logic [5:0] TK_STAR         = 6'd11;
   localparam logic [5:0] TK_STAR_EQ      = 6'd12;
   localparam logic [5:0] TK_SLASH        = 6'd13;
   localparam logic [5:0] TK_PERCENT      = 6'd14;
   localparam logic [5:0] TK_LPAR         = 6'd15;
   localparam logic [5:0] TK_RPAR         = 6'd16;
   localparam logic [5:0] TK_LBRK         = 6'd17;
   localparam logic [5:0] TK_RBRK         = 6'd18;
   localparam logic [5:0] TK_LBRACE       = 6'd19;
   localparam logic [5:0] TK_RBRACE       = 6'd20;
   localparam logic [5:0] TK_COMMA        = 6'd21;
   localparam logic [5:0] TK_SEMI         = 6'd22;
   localparam logic [5:0] TK_DOT          = 6'd23;
   localparam logic [5:0] TK_COLON        = 6'd24;
   localparam logic [5:0] TK_ASSIGN       = 6'd25;
   localparam logic [5:0] TK_EQ_EQ        = 6'd26;
   localparam logic [5:0] TK_ARROW        = 6'd27;
   localparam logic [5:0] TK_NOT          = 6'd28;
   localparam logic [5:0] TK_NOT_EQ       = 6'd29;
   localparam logic [5:0] TK_LT           = 6'd30;
   localparam logic [5:0] TK_LE           = 6'd31;
   localparam logic [5:0] TK_REV_PIPE     = 6'd32;
   localparam logic [5:0] TK_GT           = 6'd33;
   localparam logic [5:0] TK_GE           = 6'd34;
   localparam logic [5:0] TK_QUEST        = 6'd35;
   localparam logic [5:0] TK_PIPE         = 6'd36;
   localparam logic [5:0] TK_STR_START    = 6'd37;
   localparam logic [5:0] TK_STR_END      = 6'd38;
   localparam logic [5:0] TK_INTERP_START = 6'd39;
   localparam logic [5:0] TK_CONTENT      = 6'd40;
   localparam logic [5:0] TK_INTERP_END   = 6'd41;

   // error kinds
   localparam logic [3:0] ER_NONE    = 4'd0;
   localparam logic [3:0] ER_COMMENT = 4'd1;
   localparam logic [3:0] ER_NUMBER  = 4'd2;
   localparam logic [3:0] ER_NEST    = 4'd3;
   localparam logic [3:0] ER_DOLLAR  = 4'd4;
   localparam logic [3:0] ER_BAR     = 4'd5;
   localparam logic [3:0] ER_UNKNOWN = 4'd6;
   localparam logic [3:0] ER_MODE    = 4'd7;
   localparam logic [3:0] ER_UNTERM  = 4'd8;

   typedef enum logic [11:0] {
      PH_IDLE     = 12'b000000000001,
      PH_LINE     = 12'b000000000010,
      PH_BLOCK    = 12'b000000000100,
      PH_INT      = 12'b000000001000,
      PH_FRAC     = 12'b000000010000,
      PH_EXP      = 12'b000000100000,
      PH_EXP_SIGN = 12'b000001000000,
      PH_EXP_DIG  = 12'b000010000000,
      PH_IDENT    = 12'b000100000000,
      PH_SYS_WS   = 12'b001000000000,
      PH_SYS_BODY = 12'b010000000000,
      PH_CONTENT  = 12'b100000000000
   } its_phase_type;

   typedef enum logic [1:0] {
      R_ONE  = 2'd0,
      R_TWO  = 2'd1,
      R_HOLD = 2'd2
   } its_used_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  err;
      logic [23:0] start_offset;
      logic [15:0] length;
      logic [19:0] start_line;
      logic [15:0] start_column;
      logic [19:0] end_line;
      logic [15:0] end_column;
      logic        last;
   } its_tok_type;

   typedef struct packed {
      its_tok_type [MAX_RESULTS-1:0] tok;
      logic [1:0]                    cnt;
   } its_emit_type;

endpackage

`default_nettype wire

### design/its_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module its_scan #(
   parameter int MODE_STACK_DEPTH  = its_pkg::MODE_STACK_DEPTH_DEF,
   parameter int MAX_COMMENT_DEPTH = its_pkg::MAX_COMMENT_DEPTH_DEF,
   parameter int OFFSET_BITS       = its_pkg::OFFSET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           ch,
   input  logic                 end_of_source,
   output its_pkg::its_emit_type emit_out
);
   import its_pkg::*;

   localparam int TopBits   = (MODE_STACK_DEPTH > 1) ? $clog2(MODE_STACK_DEPTH) : 1;
   localparam int DepthBits = $clog2(MAX_COMMENT_DEPTH + 1);
   localparam int FeedSteps = 4;
   localparam logic [TopBits-1:0]   TopMax   = TopBits'(MODE_STACK_DEPTH - 1);
   localparam logic [DepthBits-1:0] DepthMax = DepthBits'(MAX_COMMENT_DEPTH);

   typedef struct packed {
      its_phase_type                phase;
      logic [7:0]                   la_byte;
      logic                         la_valid;
      logic [MODE_STACK_DEPTH-1:0]  stack;
      logic [TopBits-1:0]           top;
      logic [DepthBits-1:0]         cdepth;
      logic [OFFSET_BITS-1:0]       cur_off;
      logic [19:0]                  cur_line;
      logic [15:0]                  cur_col;
      logic [OFFSET_BITS-1:0]       ts_off;
      logic [19:0]                  ts_line;
      logic [15:0]                  ts_col;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      its_emit_type   em;
      its_used_type   res;
   } work_type;

   scan_state_type state_ff, state_in;

   function automatic scan_state_type reset_state();
      scan_state_type s;
      s          = '0;
      s.phase    = PH_IDLE;
      s.cur_line = 20'd1;
      s.cur_col  = 16'd1;
      s.ts_line  = 20'd1;
      s.ts_col   = 16'd1;
      return s;
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic pm(logic [8:0] p, logic [7:0] c);
      return p == {1'b0, c};
   endfunction

   function automatic scan_state_type adv(scan_state_type s, logic [7:0] c);
      scan_state_type r;
      r = s;
      if (r.cur_off != {OFFSET_BITS{1'b1}}) r.cur_off = r.cur_off + 1'b1;
      if (c == CH_LF) begin
         if (r.cur_line != LINE_MAX) r.cur_line = r.cur_line + 1'b1;
         r.cur_col = 16'd1;
      end else if (r.cur_col != COL_MAX) begin
         r.cur_col = r.cur_col + 1'b1;
      end
      return r;
   endfunction

   function automatic scan_state_type set_start(scan_state_type s);
      scan_state_type r;
      r         = s;
      r.ts_off  = s.cur_off;
      r.ts_line = s.cur_line;
      r.ts_col  = s.cur_col;
      return r;
   endfunction

   function automatic work_type emit(work_type w_in, logic [5:0] kind, logic [3:0] err);
      work_type               w;
      logic [OFFSET_BITS-1:0] diff;
      logic [31:0]            len32;
      logic [31:0]            off32;
      its_tok_type            t;
      w     = w_in;
      diff  = (w.st.cur_off >= w.st.ts_off) ? (w.st.cur_off - w.st.ts_off) : '0;
      len32 = 32'(diff);
      off32 = 32'(w.st.ts_off);
      t.kind         = kind;
      t.err          = err;
      t.start_offset = off32[23:0];
      t.length       = (len32 > 32'(LEN_MAX)) ? LEN_MAX : len32[15:0];
      t.start_line   = w.st.ts_line;
      t.start_column = w.st.ts_col;
      t.end_line     = w.st.cur_line;
      t.end_column   = w.st.cur_col;
      t.last         = 1'b0;
      if (w.em.cnt != 2'(MAX_RESULTS)) begin
         w.em.tok[w.em.cnt] = t;
         w.em.cnt           = w.em.cnt + 2'd1;
      end
      return w;
   endfunction

   // idle in default mode: whitespace, comments, numbers, names, operators, string starts, system lines
   function automatic work_type default_idle(work_type w_in, logic [7:0] c, logic [8:0] p);
      work_type   w;
      logic [5:0] kind;
      logic [3:0] err;
      logic       two;
      logic       sys;
      w    = w_in;
      kind = TK_ERR;
      err  = ER_NONE;
      two  = 1'b0;
      sys  = 1'b0;
      w.res = R_ONE;
      if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         w.st = adv(w.st, c);
      end else begin
         w.st = set_start(w.st);
         if (p == PEEK_NONE && (c == CH_HASH || c == CH_PLUS || c == CH_MINUS ||
             c == CH_STAR || c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
             c == CH_DOLLAR || c == CH_BAR)) begin
            w.res = R_HOLD;
         end else begin
            w.st = adv(w.st, c);
            if (c == CH_HASH) begin
               if (pm(p, CH_LBRACE)) begin
                  w.st        = adv(w.st, p[7:0]);
                  w.st.cdepth = DepthBits'(1);
                  w.st.phase  = PH_BLOCK;
                  w.res       = R_TWO;
               end else begin
                  w.st.phase = PH_LINE;
               end
            end else if (is_dig(c)) begin
               w.st.phase = PH_INT;
            end else if (is_letter(c)) begin
               w.st.phase = PH_IDENT;
            end else begin
               unique case (c)
                  CH_PLUS: begin
                     if (pm(p, CH_EQ)) begin kind = TK_PLUS_EQ; two = 1'b1; end
                     else if (pm(p, CH_PLUS)) begin kind = TK_PLUS_PLUS; two = 1'b1; end
                     else kind = TK_PLUS;
                  end
                  CH_MINUS: begin
                     if (pm(p, CH_EQ)) begin kind = TK_MINUS_EQ; two = 1'b1; end
                     else if (pm(p, CH_MINUS)) begin kind = TK_MINUS_MINUS; two = 1'b1; end
                     else kind = TK_MINUS;
                  end
                  CH_STAR: begin
                     if (pm(p, CH_EQ)) begin kind = TK_STAR_EQ; two = 1'b1; end
                     else kind = TK_STAR;
                  end
                  CH_EQ: begin
                     if (pm(p, CH_EQ)) begin kind = TK_EQ_EQ; two = 1'b1; end
                     else if (pm(p, CH_GT)) begin kind = TK_ARROW; two = 1'b1; end
                     else kind = TK_ASSIGN;
                  end
                  CH_BANG: begin
                     if (pm(p, CH_EQ)) begin kind = TK_NOT_EQ; two = 1'b1; end
                     else kind = TK_NOT;
                  end
                  CH_LT: begin
                     if (pm(p, CH_EQ)) begin kind = TK_LE; two = 1'b1; end
                     else if (pm(p, CH_BAR)) begin kind = TK_REV_PIPE; two = 1'b1; end
                     else kind = TK_LT;
                  end
                  CH_GT: begin
                     if (pm(p, CH_EQ)) begin kind = TK_GE; two = 1'b1; end
                     else kind = TK_GT;
                  end
                  CH_DOLLAR: begin
                     if (pm(p, CH_GT)) sys = 1'b1;
                     else err = ER_DOLLAR;
                  end
                  CH_BAR: begin
                     if (pm(p, CH_GT)) begin kind = TK_PIPE; two = 1'b1; end
                     else err = ER_BAR;
                  end
                  CH_SLASH:  kind = TK_SLASH;
                  CH_PCT:    kind = TK_PERCENT;
                  CH_LPAR:   kind = TK_LPAR;
                  CH_RPAR:   kind = TK_RPAR;
                  CH_LBRK:   kind = TK_LBRK;
                  CH_RBRK:   kind = TK_RBRK;
                  CH_LBRACE: kind = TK_LBRACE;
                  CH_RBRACE: begin
                     if (w.st.top != '0) begin
                        w.st.top = w.st.top - 1'b1;
                        kind     = TK_INTERP_END;
                     end else begin
                        kind = TK_RBRACE;
                     end
                  end
                  CH_COMMA:  kind = TK_COMMA;
                  CH_SEMI:   kind = TK_SEMI;
                  CH_DOT:    kind = TK_DOT;
                  CH_COLON:  kind = TK_COLON;
                  CH_QUEST:  kind = TK_QUEST;
                  CH_QUOTE: begin
                     if (w.st.top >= TopMax) begin
                        err = ER_NEST;
                     end else begin
                        w.st.top               = w.st.top + 1'b1;
                        w.st.stack[w.st.top]   = MODE_STR;
                        kind                   = TK_STR_START;
                     end
                  end
                  default:   err = ER_UNKNOWN;
               endcase
               if (sys) begin
                  w.st       = adv(w.st, p[7:0]);
                  w.st.phase = PH_SYS_WS;
                  w.res      = R_TWO;
               end else begin
                  if (two) begin
                     w.st  = adv(w.st, p[7:0]);
                     w.res = R_TWO;
                  end
                  w = emit(w, kind, err);
               end
            end
         end
      end
      return w;
   endfunction

   // one byte through the phase machine; p is the next byte or a marker
   function automatic work_type feed(work_type w_in, logic [7:0] c, logic [8:0] p);
      work_type w;
      logic     done;
      w     = w_in;
      w.res = R_ONE;
      done  = 1'b0;
      for (int it = 0; it < FeedSteps; it++) begin
         if (!done) begin
            unique case (w.st.phase)
               PH_LINE: begin
                  if (c == CH_LF) w.st.phase = PH_IDLE;
                  else begin w.st = adv(w.st, c); done = 1'b1; end
               end
               PH_BLOCK: begin
                  done = 1'b1;
                  if ((c == CH_HASH || c == CH_RBRACE) && p == PEEK_NONE) begin
                     w.res = R_HOLD;
                  end else if (c == CH_HASH && pm(p, CH_LBRACE)) begin
                     w.st = adv(adv(w.st, c), p[7:0]);
                     if (w.st.cdepth < DepthMax) w.st.cdepth = w.st.cdepth + 1'b1;
                     w.res = R_TWO;
                  end else if (c == CH_RBRACE && pm(p, CH_HASH)) begin
                     w.st = adv(adv(w.st, c), p[7:0]);
                     if (w.st.cdepth != '0) w.st.cdepth = w.st.cdepth - 1'b1;
                     if (w.st.cdepth == '0) w.st.phase = PH_IDLE;
                     w.res = R_TWO;
                  end else begin
                     w.st = adv(w.st, c);
                  end
               end
               PH_INT: begin
                  if (is_dig(c)) begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end else if (c == CH_DOT && p == PEEK_NONE) begin
                     w.res = R_HOLD; done = 1'b1;
                  end else if (c == CH_DOT && p[8] == 1'b0 && is_dig(p[7:0])) begin
                     w.st = adv(w.st, c); w.st.phase = PH_FRAC; done = 1'b1;
                  end else if (c == CH_LE || c == CH_UE) begin
                     w.st = adv(w.st, c); w.st.phase = PH_EXP; done = 1'b1;
                  end else begin
                     w = emit(w, TK_NUM, ER_NONE); w.st.phase = PH_IDLE;
                  end
               end
               PH_FRAC: begin
                  if (is_dig(c)) begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end else if (c == CH_LE || c == CH_UE) begin
                     w.st = adv(w.st, c); w.st.phase = PH_EXP; done = 1'b1;
                  end else begin
                     w = emit(w, TK_NUM, ER_NONE); w.st.phase = PH_IDLE;
                  end
               end
               PH_EXP: begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     w.st = adv(w.st, c); w.st.phase = PH_EXP_SIGN; done = 1'b1;
                  end else if (is_dig(c)) begin
                     w.st = adv(w.st, c); w.st.phase = PH_EXP_DIG; done = 1'b1;
                  end else begin
                     w = emit(w, TK_ERR, ER_NUMBER); w.st.phase = PH_IDLE;
                  end
               end
               PH_EXP_SIGN: begin
                  if (is_dig(c)) begin
                     w.st = adv(w.st, c); w.st.phase = PH_EXP_DIG; done = 1'b1;
                  end else begin
                     w = emit(w, TK_ERR, ER_NUMBER); w.st.phase = PH_IDLE;
                  end
               end
               PH_EXP_DIG: begin
                  if (is_dig(c)) begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end else begin
                     w = emit(w, TK_NUM, ER_NONE); w.st.phase = PH_IDLE;
                  end
               end
               PH_IDENT: begin
                  if (is_letter(c) || is_dig(c)) begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end else begin
                     w = emit(w, TK_IDENT, ER_NONE); w.st.phase = PH_IDLE;
                  end
               end
               PH_SYS_WS: begin
                  if (c == CH_SP || c == CH_TAB) begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end else begin
                     w.st = set_start(w.st); w.st.phase = PH_SYS_BODY;
                  end
               end
               PH_SYS_BODY: begin
                  if (c == CH_LF) begin
                     w = emit(w, TK_SYS, ER_NONE); w.st.phase = PH_IDLE;
                  end else begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end
               end
               PH_CONTENT: begin
                  if (c == CH_QUOTE) begin
                     w = emit(w, TK_CONTENT, ER_NONE); w.st.phase = PH_IDLE;
                  end else if ((c == CH_DOLLAR || c == CH_BSLASH) && p == PEEK_NONE) begin
                     w.res = R_HOLD; done = 1'b1;
                  end else if (c == CH_DOLLAR && pm(p, CH_LBRACE)) begin
                     w = emit(w, TK_CONTENT, ER_NONE); w.st.phase = PH_IDLE;
                  end else if (c == CH_BSLASH && p != PEEK_END) begin
                     w.st = adv(adv(w.st, c), p[7:0]); w.res = R_TWO; done = 1'b1;
                  end else begin
                     w.st = adv(w.st, c); done = 1'b1;
                  end
               end
               default: begin
                  // idle
                  w.st.phase = PH_IDLE;
                  done       = 1'b1;
                  if (w.st.stack[w.st.top] != MODE_STR) begin
                     w = default_idle(w, c, p);
                  end else begin
                     w.st = set_start(w.st);
                     if (c == CH_QUOTE) begin
                        w.st = adv(w.st, c);
                        if (w.st.top == '0) begin
                           w = emit(w, TK_ERR, ER_MODE);
                        end else begin
                           w.st.top = w.st.top - 1'b1;
                           w = emit(w, TK_STR_END, ER_NONE);
                        end
                     end else if (c == CH_DOLLAR && p == PEEK_NONE) begin
                        w.res = R_HOLD;
                     end else if (c == CH_DOLLAR && pm(p, CH_LBRACE)) begin
                        w.st = adv(adv(w.st, c), p[7:0]);
                        if (w.st.top >= TopMax) begin
                           w = emit(w, TK_ERR, ER_NEST);
                        end else begin
                           w.st.top             = w.st.top + 1'b1;
                           w.st.stack[w.st.top] = MODE_DEF;
                           w = emit(w, TK_INTERP_START, ER_NONE);
                        end
                        w.res = R_TWO;
                     end else begin
                        w.st.phase = PH_CONTENT;
                        done       = 1'b0;
                     end
                  end
               end
            endcase
         end
      end
      return w;
   endfunction

   // end of source: close what is open, then eof
   function automatic work_type finish(work_type w_in);
      work_type w;
      w = w_in;
      unique case (w.st.phase)
         PH_INT, PH_FRAC, PH_EXP_DIG: w = emit(w, TK_NUM, ER_NONE);
         PH_EXP, PH_EXP_SIGN:         w = emit(w, TK_ERR, ER_NUMBER);
         PH_IDENT:                    w = emit(w, TK_IDENT, ER_NONE);
         PH_SYS_WS: begin
            w.st = set_start(w.st);
            w    = emit(w, TK_SYS, ER_NONE);
         end
         PH_SYS_BODY:                 w = emit(w, TK_SYS, ER_NONE);
         PH_BLOCK:                    w = emit(w, TK_ERR, ER_COMMENT);
         PH_CONTENT:                  w = emit(w, TK_CONTENT, ER_NONE);
         default: begin
         end
      endcase
      w.st.phase = PH_IDLE;
      if (w.st.stack[w.st.top] == MODE_STR) begin
         w.st = set_start(w.st);
         w    = emit(w, TK_ERR, ER_UNTERM);
         if (w.st.top != '0) w.st.top = w.st.top - 1'b1;
      end
      w.st = set_start(w.st);
      w    = emit(w, TK_EOF, ER_NONE);
      return w;
   endfunction

   always_comb begin
      work_type w;
      logic     both;
      w       = '0;
      w.st    = state_ff;
      w.res   = R_ONE;
      both    = 1'b0;
      if (end_of_source) begin
         if (w.st.la_valid) begin
            w.st.la_valid = 1'b0;
            w = feed(w, w.st.la_byte, PEEK_END);
         end
         w    = finish(w);
         w.st = reset_state();
      end else begin
         if (w.st.la_valid) begin
            w.st.la_valid = 1'b0;
            w    = feed(w, w.st.la_byte, {1'b0, ch});
            both = (w.res == R_TWO);
         end
         if (!both) begin
            w = feed(w, ch, PEEK_NONE);
            if (w.res == R_HOLD) begin
               w.st.la_byte  = ch;
               w.st.la_valid = 1'b1;
            end
         end
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         w.em.tok[i].last = (2'(i) == (w.em.cnt - 2'd1));
      end
      state_in = w.st;
      emit_out = w.em;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/its_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module its_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  its_pkg::its_emit_type push,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output its_pkg::its_tok_type  head
);
   import its_pkg::*;

   localparam int PtrBits = $clog2(RSP_DEPTH);

   its_tok_type        mem_ff [RSP_DEPTH];
   logic [PtrBits-1:0] wr_ff;
   logic [PtrBits-1:0] rd_ff;
   logic [PtrBits:0]   count_ff;
   logic [1:0]         push_n;
   logic               pop;

   assign push_n    = push_en ? push.cnt : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem_ff[rd_ff];
   // room for a full burst only
   assign busy      = (count_ff > (PtrBits + 1)'(RSP_DEPTH - MAX_RESULTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + PtrBits'(push_n);
         rd_ff    <= rd_ff + PtrBits'(pop);
         count_ff <= count_ff + (PtrBits + 1)'(push_n) - (PtrBits + 1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push_n) begin
            mem_ff[wr_ff + PtrBits'(i)] <= push.tok[i];
         end
      end
   end

endmodule

`default_nettype wire

### design/interpolating_token_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// a token is registered in the result queue and offered on rsp_ from its head
// throughput: one input word per cycle while the queue holds at most one token;
//   a word yielding two or three tokens, or a stalled rsp_, holds req_ off until
//   at most one token is left in the queue
// reset: synchronous, active high; scanner back to idle in default mode, positions
//   at line 1 column 1, result queue empty; an end word restores this scanner state

module interpolating_token_scanner_core #(
   parameter int MODE_STACK_DEPTH  = its_pkg::MODE_STACK_DEPTH_DEF,
   parameter int MAX_COMMENT_DEPTH = its_pkg::MAX_COMMENT_DEPTH_DEF,
   parameter int OFFSET_BITS       = its_pkg::OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // source bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   // tokens
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [3:0]  rsp_error_kind,
   output logic [23:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [19:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [19:0] rsp_end_line,
   output logic [15:0] rsp_end_column,
   output logic        rsp_last_of_run
);
   import its_pkg::*;

   logic         accept;
   logic         busy;
   its_emit_type emit_bus;
   its_tok_type  head;

   // stall is registered: queue count alone decides it
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   // scanner state plus one pass of token logic per word
   its_scan #(
      .MODE_STACK_DEPTH  (MODE_STACK_DEPTH),
      .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH),
      .OFFSET_BITS       (OFFSET_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .ch            (req_ch),
      .end_of_source (req_end_of_source),
      .emit_out      (emit_bus)
   );

   // up to three tokens go in at once, one comes out per cycle while rsp_stall is low
   its_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (emit_bus),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_error_kind   = head.err;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_length = head.length;
   assign rsp_start_line   = head.start_line;
   assign rsp_start_column = head.start_column;
   assign rsp_end_line     = head.end_line;
   assign rsp_end_column   = head.end_column;
   assign rsp_last_of_run  = head.last;

endmodule

`default_nettype wire
